/* design/pan_tilt_pid_tracker_macros.svh */
// Assertion macros for the pan/tilt tracker checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef PAN_TILT_PID_TRACKER_MACROS_SVH
`define PAN_TILT_PID_TRACKER_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define PTPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define PTPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ptpt_pkg.sv */
// Shared types and constants for the pan/tilt PID tracker.
// No dependencies; used by the tracker, the multiplier and the checker.
package ptpt_pkg;

    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;
    localparam int HALF_ONE_Q16     = 32768;

    // Shared multiplier widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = 51;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_THRESH = 3'd7;

    // Register reset values
    localparam logic [15:0] GAIN_PROP_RST   = 16'd13107;
    localparam logic [15:0] GAIN_INT_RST    = 16'd66;
    localparam logic [15:0] GAIN_DERIV_RST  = 16'd6554;
    localparam logic [15:0] PAN_SCALE_RST   = 16'd9175;
    localparam logic [15:0] TILT_SCALE_RST  = 16'd12288;
    localparam logic [7:0]  TILT_MIN_RST    = 8'd45;
    localparam logic [7:0]  TILT_MAX_RST    = 8'd135;
    localparam logic [10:0] LOST_THRESH_RST = 11'd1000;

    localparam logic [7:0] PAN_MIN    = 8'd0;
    localparam logic [7:0] PAN_MAX    = 8'd180;
    localparam logic [7:0] DEG_CENTRE = 8'd90;

    typedef struct packed {
        logic signed [11:0] point_x;
        logic signed [11:0] point_y;
    } point_t;

    typedef struct packed {
        logic [7:0] pan_degrees;
        logic [7:0] tilt_degrees;
    } servo_t;

endpackage

/* design/pan_tilt_pid_tracker.sv */
// Top level of the two-axis PID pan/tilt tracker.
// Depends on ptpt_pkg and ptpt_mul (the shared multiplier).
//
// Usage
//   Input channel (in_valid / in_stall / in_data): one word holds a detected
//   point (point_x, point_y). A word is taken at a rising edge with in_valid
//   high and in_stall low. in_stall stays high while a point is worked on.
//   Output channel (out_valid / out_stall / out_data): one word per point with
//   the pan and tilt servo angles in whole degrees. A stalled word is held
//   unchanged until taken.
//   Configuration (cfg_we / cfg_index / cfg_data): write a register in one
//   cycle, only while the block is idle. No read-back.
// Timing
//   Each axis runs 12 steps through the sequencer around the single shared
//   17 x 34 bit multiplier (error, sum, P, D, two integral halves, aim update,
//   degree mapping, limiting), and the word is loaded in a final step. A new
//   point is taken only once the sequencer is back in idle. The output register
//   frees the input side: the next point is taken while a word still waits.
//   When the receiver stalls and a second word is ready, the sequencer holds
//   in its final step until the output register drains.
// Reset
//   rst_n clears the control state, restores the register defaults, sets both
//   aims to the image centre and clears the error sums and last errors.
module pan_tilt_pid_tracker
#(
    parameter int IMAGE_WIDTH  = ptpt_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = ptpt_pkg::IMAGE_HEIGHT_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  ptpt_pkg::point_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output ptpt_pkg::servo_t                      out_data,
    input  logic                                  cfg_we,
    input  logic [ptpt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ptpt_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Image centre in Q.16
    localparam logic signed [31:0] CENTRE_X = 32'(IMAGE_WIDTH * ptpt_pkg::HALF_ONE_Q16);
    localparam logic signed [31:0] CENTRE_Y = 32'(IMAGE_HEIGHT * ptpt_pkg::HALF_ONE_Q16);

    // Sequencer steps
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ERR     = 4'd1;
    localparam logic [3:0] S_SUM     = 4'd2;
    localparam logic [3:0] S_MUL_D   = 4'd3;
    localparam logic [3:0] S_MUL_IH  = 4'd4;
    localparam logic [3:0] S_MUL_IL  = 4'd5;
    localparam logic [3:0] S_I_ADD   = 4'd6;
    localparam logic [3:0] S_I_ACC   = 4'd7;
    localparam logic [3:0] S_AIM     = 4'd8;
    localparam logic [3:0] S_DIFF    = 4'd9;
    localparam logic [3:0] S_MUL_DEG = 4'd10;
    localparam logic [3:0] S_QUOT    = 4'd11;
    localparam logic [3:0] S_LIMIT   = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -42'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Saturate a wide signed value to 40 bits
    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        logic signed [39:0] r;
        if (v > 42'sd549755813887)
            r = 40'sh7fffffffff;
        else if (v < -42'sd549755813888)
            r = 40'sh8000000000;
        else
            r = v[39:0];
        return r;
    endfunction

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ax_reg;

    // Configuration registers
    logic [15:0] gain_prop_reg;
    logic [15:0] gain_int_reg;
    logic [15:0] gain_deriv_reg;
    logic [15:0] pan_scale_reg;
    logic [15:0] tilt_scale_reg;
    logic [7:0]  tilt_min_reg;
    logic [7:0]  tilt_max_reg;
    logic [10:0] lost_thresh_reg;

    // Loop state, one entry per axis (x = 0, y = 1)
    logic signed [31:0] aim_reg  [2];
    logic signed [39:0] sum_reg  [2];
    logic signed [31:0] last_reg [2];

    // Working registers
    logic signed [31:0] tgt_x_reg;
    logic signed [31:0] tgt_y_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] dd_reg;
    logic signed [41:0] acc_reg;
    logic signed [50:0] ih_reg;
    logic signed [56:0] ifull_reg;
    logic signed [32:0] diffc_reg;
    logic signed [19:0] q_reg;
    logic [7:0]         pan_reg;
    logic [7:0]         tilt_reg;

    logic             out_valid_reg;
    ptpt_pkg::servo_t out_data_reg;

    // Multiplier
    logic signed [ptpt_pkg::MUL_A_W-1:0] mul_a;
    logic        [ptpt_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ptpt_pkg::PROD_W-1:0]  prod;

    // Combinational helpers
    logic               in_take;
    logic               out_take;
    logic               out_free;
    logic signed [12:0] px13;
    logic signed [12:0] py13;
    logic signed [12:0] thr13;
    logic               lost;
    logic signed [31:0] aim_cur;
    logic signed [39:0] sum_cur;
    logic signed [31:0] last_cur;
    logic signed [31:0] tgt_cur;
    logic signed [31:0] centre_cur;
    logic [15:0]        scale_cur;
    logic signed [41:0] err_wide;
    logic signed [41:0] sum_wide;
    logic signed [41:0] prod_q16;
    logic signed [41:0] ifull_q16;
    logic signed [19:0] prod_q32;
    logic signed [20:0] deg_val;
    logic signed [20:0] deg_hi;
    logic signed [20:0] deg_lo;
    logic signed [20:0] deg_top;
    logic signed [20:0] deg_clamp;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Lost target: both coordinates at or above the threshold, signed compare
    assign px13  = 13'(in_data.point_x);
    assign py13  = 13'(in_data.point_y);
    assign thr13 = $signed({2'b00, lost_thresh_reg});
    assign lost  = (px13 >= thr13) && (py13 >= thr13);

    assign aim_cur    = aim_reg[ax_reg];
    assign sum_cur    = sum_reg[ax_reg];
    assign last_cur   = last_reg[ax_reg];
    assign tgt_cur    = ax_reg ? tgt_y_reg : tgt_x_reg;
    assign centre_cur = ax_reg ? CENTRE_Y : CENTRE_X;
    assign scale_cur  = ax_reg ? tilt_scale_reg : pan_scale_reg;

    assign err_wide = 42'(tgt_cur) - 42'(aim_cur);
    assign sum_wide = 42'(sum_cur) + 42'(err_reg);

    // Divide by 2^16 and 2^32 rounding toward zero: floor shift plus one when
    // negative with nonzero dropped bits
    assign prod_q16  = 42'(prod >>> 16)
                     + {41'd0, prod[ptpt_pkg::PROD_W-1] & (|prod[15:0])};
    assign ifull_q16 = 42'(ifull_reg >>> 16) + {41'd0, ifull_reg[56] & (|ifull_reg[15:0])};
    assign prod_q32  = 20'(prod >>> 32)
                     + {19'd0, prod[ptpt_pkg::PROD_W-1] & (|prod[31:0])};

    // Degree mapping and limits: upper limit first, lower limit second
    assign deg_val   = $signed({13'd0, ptpt_pkg::DEG_CENTRE}) - 21'(q_reg);
    assign deg_hi    = ax_reg ? $signed({13'd0, tilt_max_reg}) : $signed({13'd0, ptpt_pkg::PAN_MAX});
    assign deg_lo    = ax_reg ? $signed({13'd0, tilt_min_reg}) : $signed({13'd0, ptpt_pkg::PAN_MIN});
    assign deg_top   = (deg_val > deg_hi) ? deg_hi : deg_val;
    assign deg_clamp = (deg_top < deg_lo) ? deg_lo : deg_top;

    // Operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_SUM:
            begin
                mul_a = 34'(err_reg);
                mul_b = gain_prop_reg;
            end
            S_MUL_D:
            begin
                mul_a = 34'(dd_reg);
                mul_b = gain_deriv_reg;
            end
            S_MUL_IH:
            begin
                mul_a = 34'($signed(sum_cur[39:20]));
                mul_b = gain_int_reg;
            end
            S_MUL_IL:
            begin
                mul_a = {14'd0, sum_cur[19:0]};
                mul_b = gain_int_reg;
            end
            S_MUL_DEG:
            begin
                mul_a = 34'(diffc_reg);
                mul_b = scale_cur;
            end
            default:
            begin
                mul_a = 34'(err_reg);
                mul_b = gain_prop_reg;
            end
        endcase
    end

    ptpt_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Sequencer
    always_comb
    begin
        case (state_reg)
            S_IDLE:    state_next = in_take ? S_ERR : S_IDLE;
            S_ERR:     state_next = S_SUM;
            S_SUM:     state_next = S_MUL_D;
            S_MUL_D:   state_next = S_MUL_IH;
            S_MUL_IH:  state_next = S_MUL_IL;
            S_MUL_IL:  state_next = S_I_ADD;
            S_I_ADD:   state_next = S_I_ACC;
            S_I_ACC:   state_next = S_AIM;
            S_AIM:     state_next = S_DIFF;
            S_DIFF:    state_next = S_MUL_DEG;
            S_MUL_DEG: state_next = S_QUOT;
            S_QUOT:    state_next = S_LIMIT;
            S_LIMIT:   state_next = ax_reg ? S_DONE : S_ERR;
            S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_take)
                ax_reg <= 1'b0;
            else if (state_reg == S_LIMIT)
                ax_reg <= 1'b1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg   <= ptpt_pkg::GAIN_PROP_RST;
            gain_int_reg    <= ptpt_pkg::GAIN_INT_RST;
            gain_deriv_reg  <= ptpt_pkg::GAIN_DERIV_RST;
            pan_scale_reg   <= ptpt_pkg::PAN_SCALE_RST;
            tilt_scale_reg  <= ptpt_pkg::TILT_SCALE_RST;
            tilt_min_reg    <= ptpt_pkg::TILT_MIN_RST;
            tilt_max_reg    <= ptpt_pkg::TILT_MAX_RST;
            lost_thresh_reg <= ptpt_pkg::LOST_THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptpt_pkg::REG_GAIN_PROP:   gain_prop_reg   <= cfg_data;
                ptpt_pkg::REG_GAIN_INT:    gain_int_reg    <= cfg_data;
                ptpt_pkg::REG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data;
                ptpt_pkg::REG_PAN_SCALE:   pan_scale_reg   <= cfg_data;
                ptpt_pkg::REG_TILT_SCALE:  tilt_scale_reg  <= cfg_data;
                ptpt_pkg::REG_TILT_MIN:    tilt_min_reg    <= cfg_data[7:0];
                ptpt_pkg::REG_TILT_MAX:    tilt_max_reg    <= cfg_data[7:0];
                ptpt_pkg::REG_LOST_THRESH: lost_thresh_reg <= cfg_data[10:0];
                default:                   ;
            endcase
        end
    end

    // Loop state: aim starts at the image centre, sums and last errors at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aim_reg[0]  <= CENTRE_X;
            aim_reg[1]  <= CENTRE_Y;
            sum_reg[0]  <= '0;
            sum_reg[1]  <= '0;
            last_reg[0] <= '0;
            last_reg[1] <= '0;
        end
        else
        begin
            if (state_reg == S_SUM)
            begin
                sum_reg[ax_reg]  <= sat40(sum_wide);
                last_reg[ax_reg] <= err_reg;
            end
            if (state_reg == S_AIM)
                aim_reg[ax_reg] <= sat32(acc_reg);
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            // Latch both targets: image centre when lost, else the point in Q.16
            tgt_x_reg <= lost ? CENTRE_X
                              : {{4{in_data.point_x[11]}}, in_data.point_x, 16'h0000};
            tgt_y_reg <= lost ? CENTRE_Y
                              : {{4{in_data.point_y[11]}}, in_data.point_y, 16'h0000};
        end
        case (state_reg)
            S_ERR:     err_reg   <= sat32(err_wide);
            S_SUM:
            begin
                dd_reg  <= 33'(err_reg) - 33'(last_cur);
                acc_reg <= 42'(aim_cur);
            end
            S_MUL_D:   acc_reg   <= acc_reg + prod_q16;
            S_MUL_IH:  acc_reg   <= acc_reg + prod_q16;
            S_MUL_IL:  ih_reg    <= prod;
            S_I_ADD:   ifull_reg <= (57'(ih_reg) <<< 20) + 57'(prod);
            S_I_ACC:   acc_reg   <= acc_reg + ifull_q16;
            S_DIFF:    diffc_reg <= 33'(aim_cur) - 33'(centre_cur);
            S_QUOT:    q_reg     <= prod_q32;
            S_LIMIT:
            begin
                if (ax_reg)
                    tilt_reg <= deg_clamp[7:0];
                else
                    pan_reg <= deg_clamp[7:0];
            end
            default:   ;
        endcase
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.pan_degrees  <= pan_reg;
            out_data_reg.tilt_degrees <= tilt_reg;
        end
    end

endmodule

/* design/ptpt_mul.sv */
// Shared registered multiplier: signed operand times unsigned Q0.16 operand.
// Depends on ptpt_pkg for operand and product widths.
module ptpt_mul
(
    input  logic                                clk,
    input  logic signed [ptpt_pkg::MUL_A_W-1:0] a,
    input  logic        [ptpt_pkg::MUL_B_W-1:0] b,
    output logic signed [ptpt_pkg::PROD_W-1:0]  prod
);

    logic signed [ptpt_pkg::PROD_W-1:0] prod_reg;

    // b is unsigned: widen with a zero sign bit
    always_ff @(posedge clk)
    begin
        prod_reg <= ptpt_pkg::PROD_W'(a) * ptpt_pkg::PROD_W'($signed({1'b0, b}));
    end

    assign prod = prod_reg;

endmodule

/* design/ptpt_checker.sv */
// Port-level checker for the pan/tilt tracker, bound to the top level.
// Depends on ptpt_pkg and pan_tilt_pid_tracker_macros.svh.
`include "pan_tilt_pid_tracker_macros.svh"

module ptpt_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input ptpt_pkg::servo_t out_data
);

    // Hold a stalled output word
    `PTPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
    `PTPT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled word changed")

    // Busy right after a point is taken, and no word appears at once
    `PTPT_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "not busy after taking a point")
    `PTPT_ASSERT_NEXT(a_no_early, in_valid && !in_stall && !out_valid, !out_valid, "word too early")

    // Pan stays in the servo range
    `PTPT_ASSERT_SAME(a_pan_range, out_valid, out_data.pan_degrees <= ptpt_pkg::PAN_MAX, "pan out of range")

endmodule

bind pan_tilt_pid_tracker ptpt_checker u_ptpt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* test/pan_tilt_pid_tracker_tb.sv */
// Self-checking bench for the pan/tilt PID tracker: random and directed points
// under several register settings and handshake pressures. Needs ptpt_pkg and the RTL.
`timescale 1ns / 100ps

module pan_tilt_pid_tracker_tb;

    localparam int     RESET_CYCLES  = 8;
    localparam int     LIMIT_CYCLES  = 400000;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     PHASE_POINTS  = 95;
    localparam longint Q16      = 64'sd65536;
    localparam longint Q32      = 64'sd4294967296;
    localparam longint S32_LO   = -64'sd2147483648;
    localparam longint S32_HI   = 64'sd2147483647;
    localparam longint S40_LO   = -64'sd549755813888;
    localparam longint S40_HI   = 64'sd549755813887;
    localparam longint CENTRE_X = longint'(ptpt_pkg::IMAGE_WIDTH_DEF) * ptpt_pkg::HALF_ONE_Q16;
    localparam longint CENTRE_Y = longint'(ptpt_pkg::IMAGE_HEIGHT_DEF) * ptpt_pkg::HALF_ONE_Q16;
    localparam int     IMG_W    = ptpt_pkg::IMAGE_WIDTH_DEF;
    localparam int     IMG_H    = ptpt_pkg::IMAGE_HEIGHT_DEF;

    // One axis of the loop: aim and last error are Q.16 at 32 bits, the sum at 40 bits.
    typedef struct packed {
        logic signed [31:0] aim;
        logic signed [39:0] err_sum;
        logic signed [31:0] last_err;
    } axis_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    ptpt_pkg::point_t                in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    ptpt_pkg::servo_t                out_data;
    logic                            cfg_we    = 1'b0;
    logic [ptpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ptpt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Register image kept alongside the block
    logic [15:0] gain_prop;
    logic [15:0] gain_int;
    logic [15:0] gain_deriv;
    logic [15:0] pan_scale;
    logic [15:0] tilt_scale;
    logic [7:0]  tilt_min;
    logic [7:0]  tilt_max;
    logic [10:0] lost_thresh;

    axis_t axis_x;
    axis_t axis_y;

    ptpt_pkg::point_t points_pending[$];
    ptpt_pkg::servo_t servo_expected[$];

    int points_offered  = 0;
    int points_taken    = 0;
    int words_checked   = 0;
    int mismatch_count  = 0;
    int settings_count  = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    pan_tilt_pid_tracker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Loop arithmetic
    // ------------------------------------------------------------------

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance one axis by one PID step towards the target (Q.16). Every divide by a
    // power of two truncates toward zero, as the signed divide does.
    function automatic axis_t pid_advance(axis_t ax, longint target);
        longint err;
        longint sum;
        longint p;
        longint i;
        longint d;
        axis_t  nx;
        err = clamp(target - longint'(ax.aim), S32_LO, S32_HI);
        sum = clamp(longint'(ax.err_sum) + err, S40_LO, S40_HI);
        p = (longint'(gain_prop) * err) / Q16;
        i = (longint'(gain_int) * sum) / Q16;
        d = (longint'(gain_deriv) * (err - longint'(ax.last_err))) / Q16;
        nx.aim      = 32'(clamp(longint'(ax.aim) + p + i + d, S32_LO, S32_HI));
        nx.err_sum  = 40'(sum);
        nx.last_err = 32'(err);
        return nx;
    endfunction

    // Map an aim to whole degrees: the scaled offset from centre is truncated
    // toward zero before it comes off 90.
    function automatic longint servo_angle(logic signed [31:0] aim, longint centre,
                                           logic [15:0] scale);
        return longint'(ptpt_pkg::DEG_CENTRE)
               - ((longint'(aim) - centre) * longint'(scale)) / Q32;
    endfunction

    // Work out the servo word for one point and advance both axes.
    function automatic ptpt_pkg::servo_t track_point(ptpt_pkg::point_t pt);
        longint           px;
        longint           py;
        longint           pan;
        longint           tilt;
        logic             lost;
        ptpt_pkg::servo_t s;
        px = longint'(pt.point_x);
        py = longint'(pt.point_y);
        // Signed compare: a negative coordinate always counts as a detection
        lost = (px >= longint'(lost_thresh)) && (py >= longint'(lost_thresh));
        axis_x = pid_advance(axis_x, lost ? CENTRE_X : px * Q16);
        axis_y = pid_advance(axis_y, lost ? CENTRE_Y : py * Q16);
        pan  = clamp(servo_angle(axis_x.aim, CENTRE_X, pan_scale),
                     longint'(ptpt_pkg::PAN_MIN), longint'(ptpt_pkg::PAN_MAX));
        tilt = servo_angle(axis_y.aim, CENTRE_Y, tilt_scale);
        // Upper limit first, lower limit last: crossed limits give tilt_min
        if (tilt > longint'(tilt_max))
        begin
            tilt = longint'(tilt_max);
        end
        if (tilt < longint'(tilt_min))
        begin
            tilt = longint'(tilt_min);
        end
        s.pan_degrees  = pan[7:0];
        s.tilt_degrees = tilt[7:0];
        return s;
    endfunction

    task automatic restore_defaults();
        gain_prop   = ptpt_pkg::GAIN_PROP_RST;
        gain_int    = ptpt_pkg::GAIN_INT_RST;
        gain_deriv  = ptpt_pkg::GAIN_DERIV_RST;
        pan_scale   = ptpt_pkg::PAN_SCALE_RST;
        tilt_scale  = ptpt_pkg::TILT_SCALE_RST;
        tilt_min    = ptpt_pkg::TILT_MIN_RST;
        tilt_max    = ptpt_pkg::TILT_MAX_RST;
        lost_thresh = ptpt_pkg::LOST_THRESH_RST;
        axis_x = '{aim: 32'(CENTRE_X), err_sum: '0, last_err: '0};
        axis_y = '{aim: 32'(CENTRE_Y), err_sum: '0, last_err: '0};
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("mismatch at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Input side: predict the servo word for every point the block takes.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            servo_expected = {servo_expected, track_point(in_data)};
            points_taken <= points_taken + 1;
        end
    end

    // Output side: compare every word taken with the oldest prediction.
    always @(posedge clk)
    begin
        ptpt_pkg::servo_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (servo_expected.size() == 0)
            begin
                report_mismatch("servo word with no point pending", int'(out_data), -1);
            end
            else
            begin
                want = servo_expected.pop_front();
                if (out_data.pan_degrees !== want.pan_degrees)
                begin
                    report_mismatch("pan_degrees", int'(out_data.pan_degrees),
                                    int'(want.pan_degrees));
                end
                if (out_data.tilt_degrees !== want.tilt_degrees)
                begin
                    report_mismatch("tilt_degrees", int'(out_data.tilt_degrees),
                                    int'(want.tilt_degrees));
                end
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving, on the falling edge
    // ------------------------------------------------------------------

    // Hold the offered word until taken, then offer the next one or idle at
    // random. The receiver stalls at random at its own rate.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || points_taken == points_offered)
            begin
                if (points_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= points_pending.pop_front();
                    points_offered <= points_offered + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Mostly points inside the image, then wide-range noise, lost pairs,
    // threshold edges and the corners of the 12-bit range.
    function automatic ptpt_pkg::point_t random_point();
        ptpt_pkg::point_t pt;
        int               pick;
        int               x;
        int               y;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            x = $urandom_range(0, IMG_W - 1);
            y = $urandom_range(0, IMG_H - 1);
        end
        else if (pick < 70)
        begin
            x = $urandom;
            y = $urandom;
        end
        else if (pick < 85)
        begin
            x = $urandom_range(lost_thresh, 2047);
            y = $urandom_range(lost_thresh, 2047);
        end
        else if (pick < 93)
        begin
            x = int'(lost_thresh) - $urandom_range(0, 1);
            y = int'(lost_thresh) - $urandom_range(0, 1);
        end
        else
        begin
            x = $urandom_range(0, 1) ? 2047 : -2048;
            y = $urandom_range(0, 1) ? 2047 : -2048;
        end
        pt.point_x = x[11:0];
        pt.point_y = y[11:0];
        return pt;
    endfunction

    task automatic push_point(int x, int y);
        ptpt_pkg::point_t pt;
        pt.point_x = x[11:0];
        pt.point_y = y[11:0];
        points_pending = {points_pending, pt};
    endtask

    // Wait until every point has gone through and its word has been checked.
    task automatic wait_idle();
        while (points_pending.size() != 0 || in_valid || servo_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [ptpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptpt_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        // Narrow registers keep only their low bits
        case (idx)
            ptpt_pkg::REG_GAIN_PROP:   gain_prop   = data;
            ptpt_pkg::REG_GAIN_INT:    gain_int    = data;
            ptpt_pkg::REG_GAIN_DERIV:  gain_deriv  = data;
            ptpt_pkg::REG_PAN_SCALE:   pan_scale   = data;
            ptpt_pkg::REG_TILT_SCALE:  tilt_scale  = data;
            ptpt_pkg::REG_TILT_MIN:    tilt_min    = data[7:0];
            ptpt_pkg::REG_TILT_MAX:    tilt_max    = data[7:0];
            ptpt_pkg::REG_LOST_THRESH: lost_thresh = data[10:0];
            default:                   ;
        endcase
    endtask

    task automatic set_config(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                              logic [15:0] ps, logic [15:0] ts, logic [15:0] tmin,
                              logic [15:0] tmax, logic [15:0] thr);
        write_reg(ptpt_pkg::REG_GAIN_PROP,   kp);
        write_reg(ptpt_pkg::REG_GAIN_INT,    ki);
        write_reg(ptpt_pkg::REG_GAIN_DERIV,  kd);
        write_reg(ptpt_pkg::REG_PAN_SCALE,   ps);
        write_reg(ptpt_pkg::REG_TILT_SCALE,  ts);
        write_reg(ptpt_pkg::REG_TILT_MIN,    tmin);
        write_reg(ptpt_pkg::REG_TILT_MAX,    tmax);
        write_reg(ptpt_pkg::REG_LOST_THRESH, thr);
        settings_count++;
    endtask

    // Random gains kept moderate so the loop does not always pin; junk in the
    // unused high bits of the narrow registers.
    task automatic set_random_config(int tmin, int tmax);
        set_config(16'($urandom_range(0, 40000)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 30000)), 16'($urandom_range(0, 20000)),
                   16'($urandom_range(0, 20000)), {8'($urandom), 8'(tmin)},
                   {8'($urandom), 8'(tmax)}, {5'($urandom), 11'($urandom_range(0, 2047))});
    endtask

    task automatic run_points(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) points_pending = {points_pending, random_point()};
        wait_idle();
    endtask

    initial
    begin
        restore_defaults();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed points under the reset settings, no idling: corners of the
        // coordinate range, lost target exactly at the threshold and one short
        // of it, negative coordinates against a large partner, image centre.
        push_point(0, 0);
        push_point(IMG_W / 2, IMG_H / 2);
        push_point(IMG_W - 1, IMG_H - 1);
        push_point(-2048, -2048);
        push_point(2047, 2047);
        push_point(2047, -2048);
        push_point(-2048, 2047);
        push_point(1000, 1000);
        push_point(999, 1000);
        push_point(1000, 999);
        push_point(-1, 2047);
        push_point(2047, -1);
        push_point(1000, 2047);
        push_point(-1, -1);
        push_point(12'h555, 12'h2aa);
        push_point(12'h2aa, 12'h555);
        push_point(IMG_W - 1, 0);
        push_point(0, IMG_H - 1);
        wait_idle();

        // Reset values written back, junk in the high bits; sender gaps
        set_config(ptpt_pkg::GAIN_PROP_RST, ptpt_pkg::GAIN_INT_RST,
                   ptpt_pkg::GAIN_DERIV_RST, ptpt_pkg::PAN_SCALE_RST,
                   ptpt_pkg::TILT_SCALE_RST, {8'hA5, ptpt_pkg::TILT_MIN_RST},
                   {8'h5A, ptpt_pkg::TILT_MAX_RST}, {5'h15, ptpt_pkg::LOST_THRESH_RST});
        run_points(PHASE_POINTS, 51, 0);

        // Everything zero: the aim freezes, tilt pinned at 0, any
        // non-negative pair counts as lost; receiver stalls
        set_config('0, '0, '0, '0, '0, '0, '0, '0);
        run_points(PHASE_POINTS, 0, 51);

        // Crossed tilt limits: tilt always reads tilt_min; no idling
        set_random_config(150, 30);
        run_points(PHASE_POINTS, 0, 0);

        set_random_config($urandom_range(0, 180), $urandom_range(0, 255));
        run_points(PHASE_POINTS, 7, 7);

        set_random_config($urandom_range(0, 90), $urandom_range(90, 180));
        run_points(PHASE_POINTS, 51, 0);

        // Every gain and scale at full: drives error, sum and aim into
        // saturation; tilt limits 0..255 so tilt can pass 180
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00,
                   16'hFFFF, 16'hFFFF);
        run_points(PHASE_POINTS, 0, 51);

        set_random_config($urandom_range(0, 180), $urandom_range(0, 255));
        run_points(PHASE_POINTS, 7, 7);

        // Drain, then allow any stray word time to show up
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Tracked %0d points across %0d register settings, %0d servo words checked,",
                 points_taken, settings_count, words_checked);
        $display("with sender gaps and receiver stalls from none up to half the cycles.");
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timed out after %0d cycles, %0d words still expected",
                 cycle_count, servo_expected.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
